### rtl/core/sorted_table_time_code_match_defines.svh
// Assertion macros used by the file that checks this block.
`ifndef SORTED_TABLE_TIME_CODE_MATCH_DEFINES_SVH
`define SORTED_TABLE_TIME_CODE_MATCH_DEFINES_SVH

`ifndef ASSERT_OFF

`define STCM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("stcm check failed");

`define STCM_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("stcm forbidden condition");

`else

`define STCM_ASSERT(label, prop)

`define STCM_NEVER(label, expr)

`endif

`endif

### rtl/core/stcm_pkg.sv
package stcm_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int BRACKET_SPAN = 10;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int TIME_W       = 32;
    localparam int CODE_W       = 16;
    localparam int ENTRY_W      = TIME_W + CODE_W;
    localparam int FUNC_W       = 2;
    localparam int MATCH_W      = 10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_MATCH    = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LB_RD,
        S_LB_CMP,
        S_UB_RD,
        S_UB_CMP,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [MATCH_W-1:0] index;
        logic [CNT_W-1:0]   fill;
    } res_t;

endpackage

### rtl/core/stcm_ram.sv
module stcm_ram (
    input  logic                        clk,
    input  stcm_pkg::ram_req_t          req,
    output logic [stcm_pkg::ENTRY_W-1:0] rdata
);

    logic [stcm_pkg::ENTRY_W-1:0] mem [stcm_pkg::TABLE_DEPTH];
    logic [stcm_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/stcm_ctrl.sv
module stcm_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stcm_pkg::FUNC_W-1:0]         func,
    input  logic [stcm_pkg::TIME_W-1:0]         entry_time,
    input  logic signed [stcm_pkg::CODE_W-1:0]  entry_code,
    input  logic [stcm_pkg::TIME_W-1:0]         query_time,
    input  logic signed [stcm_pkg::CODE_W-1:0]  query_code,
    input  logic                                res_take,
    output stcm_pkg::res_t                      res,
    output stcm_pkg::ram_req_t                  ram_req,
    input  logic [stcm_pkg::ENTRY_W-1:0]        ram_rdata
);

    stcm_pkg::state_t state_reg, state_next;

    logic [stcm_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [stcm_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [stcm_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [stcm_pkg::ADDR_W-1:0] mid_reg, mid_next;
    logic [stcm_pkg::CNT_W-1:0]  start_reg, start_next;
    logic [stcm_pkg::CNT_W-1:0]  stop_reg, stop_next;
    logic [stcm_pkg::CNT_W-1:0]  scan_reg, scan_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [stcm_pkg::ADDR_W-1:0] chk_idx_reg, chk_idx_next;
    logic [stcm_pkg::TIME_W-1:0] qtime_reg, qtime_next;
    logic [stcm_pkg::CODE_W-1:0] qcode_reg, qcode_next;
    stcm_pkg::status_t           res_status_reg, res_status_next;
    logic [stcm_pkg::MATCH_W-1:0] res_index_reg, res_index_next;

    logic                        accept;
    logic [stcm_pkg::CNT_W:0]    mid_sum;
    logic [stcm_pkg::CNT_W-1:0]  mid_full;
    logic                        bracket_go;
    logic                        scan_issue;
    logic                        chk_hit;
    logic                        table_full;
    logic [stcm_pkg::TIME_W-1:0] rd_time;
    logic [stcm_pkg::CODE_W-1:0] rd_code;

    assign accept     = in_valid && in_ready;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full   = mid_sum[stcm_pkg::CNT_W:1];
    assign bracket_go = (hi_reg - lo_reg) > stcm_pkg::CNT_W'(stcm_pkg::BRACKET_SPAN);
    assign scan_issue = (scan_reg < stop_reg) && (scan_reg < count_reg);
    assign rd_time    = ram_rdata[stcm_pkg::ENTRY_W-1:stcm_pkg::CODE_W];
    assign rd_code    = ram_rdata[stcm_pkg::CODE_W-1:0];
    assign chk_hit    = chk_valid_reg && (rd_time == qtime_reg) && (rd_code == qcode_reg);
    assign table_full = count_reg >= stcm_pkg::CNT_W'(stcm_pkg::TABLE_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stcm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (func == stcm_pkg::FUNC_QUERY)
                    begin
                        state_next = stcm_pkg::S_LB_RD;
                    end
                    else
                    begin
                        state_next = stcm_pkg::S_RESULT;
                    end
                end
            end
            stcm_pkg::S_LB_RD:
            begin
                state_next = bracket_go ? stcm_pkg::S_LB_CMP : stcm_pkg::S_UB_RD;
            end
            stcm_pkg::S_LB_CMP:
            begin
                state_next = stcm_pkg::S_LB_RD;
            end
            stcm_pkg::S_UB_RD:
            begin
                state_next = bracket_go ? stcm_pkg::S_UB_CMP : stcm_pkg::S_SCAN;
            end
            stcm_pkg::S_UB_CMP:
            begin
                state_next = stcm_pkg::S_UB_RD;
            end
            stcm_pkg::S_SCAN:
            begin
                if (chk_hit || (!scan_issue && !chk_valid_reg))
                begin
                    state_next = stcm_pkg::S_RESULT;
                end
            end
            stcm_pkg::S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = stcm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stcm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        ram_req.rd_en = 1'b0;
        ram_req.wr_en = 1'b0;
        ram_req.addr  = mid_full[stcm_pkg::ADDR_W-1:0];
        ram_req.wdata = {entry_time, entry_code};
        unique case (state_reg)
            stcm_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                ram_req.addr  = count_reg[stcm_pkg::ADDR_W-1:0];
                ram_req.wr_en = accept && (func == stcm_pkg::FUNC_APPEND) && !table_full;
            end
            stcm_pkg::S_LB_RD, stcm_pkg::S_UB_RD:
            begin
                ram_req.rd_en = bracket_go;
            end
            stcm_pkg::S_SCAN:
            begin
                ram_req.addr  = scan_reg[stcm_pkg::ADDR_W-1:0];
                ram_req.rd_en = scan_issue;
            end
            default:
            begin
                ram_req.rd_en = 1'b0;
            end
        endcase
        res.valid  = (state_reg == stcm_pkg::S_RESULT);
        res.status = res_status_reg;
        res.index  = res_index_reg;
        res.fill   = count_reg;
    end

    always_comb
    begin
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        start_next      = start_reg;
        stop_next       = stop_reg;
        scan_next       = scan_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        qtime_next      = qtime_reg;
        qcode_next      = qcode_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        case (state_reg)
            stcm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = stcm_pkg::ST_DONE;
                    res_index_next  = '0;
                    unique case (func)
                        stcm_pkg::FUNC_APPEND:
                        begin
                            if (table_full)
                            begin
                                res_status_next = stcm_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        stcm_pkg::FUNC_QUERY:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            qtime_next = query_time;
                            qcode_next = query_code;
                        end
                        stcm_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            stcm_pkg::S_LB_RD:
            begin
                mid_next = mid_full[stcm_pkg::ADDR_W-1:0];
                if (!bracket_go)
                begin
                    start_next = lo_reg;
                    lo_next    = '0;
                    hi_next    = count_reg;
                end
            end
            stcm_pkg::S_LB_CMP:
            begin
                if (rd_time < qtime_reg)
                begin
                    lo_next = stcm_pkg::CNT_W'(mid_reg);
                end
                else
                begin
                    hi_next = stcm_pkg::CNT_W'(mid_reg) + 1'b1;
                end
            end
            stcm_pkg::S_UB_RD:
            begin
                mid_next = mid_full[stcm_pkg::ADDR_W-1:0];
                if (!bracket_go)
                begin
                    stop_next = hi_reg;
                    scan_next = start_reg;
                end
            end
            stcm_pkg::S_UB_CMP:
            begin
                if (rd_time > qtime_reg)
                begin
                    hi_next = stcm_pkg::CNT_W'(mid_reg);
                end
                else
                begin
                    lo_next = stcm_pkg::CNT_W'(mid_reg) - 1'b1;
                end
            end
            stcm_pkg::S_SCAN:
            begin
                if (chk_hit)
                begin
                    res_status_next = stcm_pkg::ST_MATCH;
                    res_index_next  = stcm_pkg::MATCH_W'(chk_idx_reg);
                end
                else if (!scan_issue && !chk_valid_reg)
                begin
                    res_status_next = stcm_pkg::ST_NO_MATCH;
                    res_index_next  = '0;
                end
                else if (scan_issue)
                begin
                    scan_next      = scan_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[stcm_pkg::ADDR_W-1:0];
                end
            end
            default:
            begin
                chk_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stcm_pkg::S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        start_reg      <= start_next;
        stop_reg       <= stop_next;
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        qtime_reg      <= qtime_next;
        qcode_reg      <= qcode_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
    end

endmodule

### rtl/core/sorted_table_time_code_match.sv
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------------
// in       in_valid / in_ready  func, entry_time, entry_code, query_time, query_code
// out      out_valid/out_ready  status, match_index
//
// Append, clear and the unused function code pass from the input transaction to the
// result state and into the output register once it is free; then the next input is taken.
// A query runs two binary brackets, lower bound and then upper bound (about
// log2(count / 10) steps each, each step a read state and a compare state), then scans
// the bracketed indices one read at a time through the single read port of the entry memory.
// Reset clears the entry count; the entry memory keeps its contents and is not swept.
// A result waiting in the output register does not block the next input transaction;
// only a second finished result waits until the output register is free.
`include "sorted_table_time_code_match_defines.svh"

module sorted_table_time_code_match (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stcm_pkg::FUNC_W-1:0]         func,
    input  logic [stcm_pkg::TIME_W-1:0]         entry_time,
    input  logic signed [stcm_pkg::CODE_W-1:0]  entry_code,
    input  logic [stcm_pkg::TIME_W-1:0]         query_time,
    input  logic signed [stcm_pkg::CODE_W-1:0]  query_code,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [stcm_pkg::MATCH_W-1:0]        match_index
);

    stcm_pkg::res_t               res;
    stcm_pkg::ram_req_t           ram_req;
    logic [stcm_pkg::ENTRY_W-1:0] ram_rdata;
    logic                         res_take;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   status_reg;
    logic [stcm_pkg::MATCH_W-1:0] index_reg;

    logic                         res_is_match;
    logic                         res_is_full;
    logic [stcm_pkg::CNT_W-1:0]   res_index_ext;

    stcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .entry_time (entry_time),
        .entry_code (entry_code),
        .query_time (query_time),
        .query_code (query_code),
        .res_take   (res_take),
        .res        (res),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    stcm_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            status_reg <= res.status;
            index_reg  <= res.index;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign match_index = index_reg;

    assign res_is_match  = res.valid && (res.status == stcm_pkg::ST_MATCH);
    assign res_is_full   = res.valid && (res.status == stcm_pkg::ST_FULL);
    assign res_index_ext = stcm_pkg::CNT_W'(res.index);

    `STCM_NEVER(a_idle_without_result, in_ready && res.valid)
    `STCM_ASSERT(a_match_below_fill, res_is_match |-> res_index_ext < res.fill)
    `STCM_ASSERT(a_full_only_when_full, res_is_full |-> res.fill == stcm_pkg::CNT_W'(stcm_pkg::TABLE_DEPTH))
    `STCM_ASSERT(a_index_zero_no_match, res.valid && !res_is_match |-> res.index == '0)

endmodule
